[rtl/eul_pkg.sv]
// Package for the Euler angle to rotation matrix block.
// Fixed-point constants, the CORDIC arctangent table and payload types.
// No dependencies.
package eul_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_LEN         = 24;

    // CORDIC datapath: Q.30 radians and Q.30 vector components
    localparam int CW = 34;
    // sine/cosine in Q1.20, clamped to +-2^20
    localparam int SW = 22;
    // products of two factors, Q.40
    localparam int PW = 2 * SW;
    // matrix accumulation width, Q.60
    localparam int AW = 68;

    localparam logic signed [CW-1:0] Q30_PI      = 34'sd3373259426;
    localparam logic signed [CW-1:0] Q30_HALF_PI = 34'sd1686629713;
    localparam logic signed [CW-1:0] Q30_GAIN    = 34'sd652032874;
    localparam logic signed [SW-1:0] Q20_ONE     = 22'sd1048576;
    localparam logic signed [15:0]   Q14_ONE     = 16'sd16384;

    localparam logic signed [CW-1:0] ATAN_Q30 [ATAN_LEN] = '{
        34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
        34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
        34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
        34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
        34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
        34'sd1024,      34'sd512,       34'sd256,       34'sd128
    };

    typedef logic signed [15:0]   t_ang;
    typedef logic signed [15:0]   t_q14;
    typedef logic signed [SW-1:0] t_q20;

    typedef struct packed {
        t_q20 sx;
        t_q20 cx;
        t_q20 sy;
        t_q20 cy;
        t_q20 sz;
        t_q20 cz;
    } t_sincos;

    typedef struct packed {
        t_q14 m00;
        t_q14 m01;
        t_q14 m02;
        t_q14 m10;
        t_q14 m11;
        t_q14 m12;
        t_q14 m20;
        t_q14 m21;
        t_q14 m22;
    } t_matrix;

    // round Q.60 to nearest Q1.14 (halves up), saturate to unity
    function automatic t_q14 f_q14(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] r;
        r = (v + (68'sd1 <<< 45)) >>> 46;
        if (r > 68'(Q14_ONE)) begin
            return Q14_ONE;
        end else if (r < -68'(Q14_ONE)) begin
            return -Q14_ONE;
        end
        return r[15:0];
    endfunction

endpackage

[rtl/eul_angle_if.sv]
// Input channel: one roll/pitch/yaw triple per transfer.
// Depends on eul_pkg.
interface eul_angle_if;
    import eul_pkg::*;
    logic valid;
    logic ready;
    t_ang roll;
    t_ang pitch;
    t_ang yaw;
    modport source (output valid, output roll, output pitch, output yaw, input ready);
    modport sink   (input valid, input roll, input pitch, input yaw, output ready);
endinterface

[rtl/eul_matrix_if.sv]
// Output channel: nine Q1.14 matrix entries per transfer.
// Depends on eul_pkg.
interface eul_matrix_if;
    import eul_pkg::*;
    logic valid;
    logic ready;
    t_q14 m00;
    t_q14 m01;
    t_q14 m02;
    t_q14 m10;
    t_q14 m11;
    t_q14 m12;
    t_q14 m20;
    t_q14 m21;
    t_q14 m22;
    modport source (output valid, output m00, output m01, output m02, output m10,
                    output m11, output m12, output m20, output m21, output m22,
                    input ready);
    modport sink   (input valid, input m00, input m01, input m02, input m10,
                    input m11, input m12, input m20, input m21, input m22,
                    output ready);
endinterface

[rtl/eul_cfg_if.sv]
// Configuration write channel: negate_angles bit, no address.
// No dependencies.
interface eul_cfg_if;
    logic valid;
    logic ready;
    logic data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/eul_cordic.sv]
// Pipelined CORDIC sine/cosine for one angle lane: fold stage, one stage per
// rotation, then a rounding stage. Depends on eul_pkg.
module eul_cordic #(
    parameter int NSTEP = 16
) (
    input  logic                i_clk,
    input  logic [NSTEP+1:0]    i_en,
    input  logic                i_neg,
    input  eul_pkg::t_ang       i_ang,
    output eul_pkg::t_q20       o_sin,
    output eul_pkg::t_q20       o_cos
);
    import eul_pkg::*;

    logic signed [CW-1:0] r_x [0:NSTEP];
    logic signed [CW-1:0] r_y [0:NSTEP];
    logic signed [CW-1:0] r_z [0:NSTEP];
    logic                 r_f [0:NSTEP];
    t_q20                 r_sin;
    t_q20                 r_cos;

    logic signed [16:0]   a17;
    logic signed [CW-1:0] z0;
    logic signed [CW-1:0] n_z0;
    logic                 n_f0;

    // negate at 17 bits so the most negative code maps to +4 rad
    always_comb begin
        a17 = i_neg ? -{i_ang[15], i_ang} : {i_ang[15], i_ang};
        z0  = CW'(a17) <<< 17;
        n_z0 = z0;
        n_f0 = 1'b0;
        if (z0 > Q30_HALF_PI) begin
            n_z0 = z0 - Q30_PI;
            n_f0 = 1'b1;
        end else if (z0 < -Q30_HALF_PI) begin
            n_z0 = z0 + Q30_PI;
            n_f0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_x[0] <= Q30_GAIN;
            r_y[0] <= '0;
            r_z[0] <= n_z0;
            r_f[0] <= n_f0;
        end
    end

    for (genvar i = 0; i < NSTEP; i++) begin : g_step
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        assign dx = r_y[i] >>> i;
        assign dy = r_x[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (i_en[i+1]) begin
                r_f[i+1] <= r_f[i];
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - dx;
                    r_y[i+1] <= r_y[i] + dy;
                    r_z[i+1] <= r_z[i] - ATAN_Q30[i];
                end else begin
                    r_x[i+1] <= r_x[i] + dx;
                    r_y[i+1] <= r_y[i] - dy;
                    r_z[i+1] <= r_z[i] + ATAN_Q30[i];
                end
            end
        end
    end

    function automatic t_q20 f_rnd(input logic signed [CW-1:0] v, input logic flip);
        logic signed [CW-1:0] r;
        t_q20                 c;
        r = (v + CW'(512)) >>> 10;
        if (r > CW'(Q20_ONE)) begin
            c = Q20_ONE;
        end else if (r < -CW'(Q20_ONE)) begin
            c = -Q20_ONE;
        end else begin
            c = r[SW-1:0];
        end
        return flip ? -c : c;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en[NSTEP+1]) begin
            r_sin <= f_rnd(r_y[NSTEP], r_f[NSTEP]);
            r_cos <= f_rnd(r_x[NSTEP], r_f[NSTEP]);
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

[rtl/eul_mat.sv]
// Matrix product pipeline: pair products, split triple products, sums,
// then rounding to Q1.14. Four register stages. Depends on eul_pkg.
module eul_mat (
    input  logic              i_clk,
    input  logic [3:0]        i_en,
    input  eul_pkg::t_sincos  i_sc,
    output eul_pkg::t_matrix  o_mat
);
    import eul_pkg::*;

    localparam int HW = PW - SW;   // high half width of a pair product

    // stage b: pair products
    logic signed [PW-1:0] r_czcy, r_szcx, r_czsy, r_szsx, r_szcy;
    logic signed [PW-1:0] r_czcx, r_szsy, r_czsx, r_cysx, r_cycx;
    t_q20                 r_b_sx, r_b_cx, r_b_sy;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_czcy <= i_sc.cz * i_sc.cy;
            r_szcx <= i_sc.sz * i_sc.cx;
            r_czsy <= i_sc.cz * i_sc.sy;
            r_szsx <= i_sc.sz * i_sc.sx;
            r_szcy <= i_sc.sz * i_sc.cy;
            r_czcx <= i_sc.cz * i_sc.cx;
            r_szsy <= i_sc.sz * i_sc.sy;
            r_czsx <= i_sc.cz * i_sc.sx;
            r_cysx <= i_sc.cy * i_sc.sx;
            r_cycx <= i_sc.cy * i_sc.cx;
            r_b_sx <= i_sc.sx;
            r_b_cx <= i_sc.cx;
            r_b_sy <= i_sc.sy;
        end
    end

    // stage c: triple products as hi*s and lo*s partial products
    logic signed [HW-1:0] czsy_hi, szsy_hi;
    logic signed [SW:0]   czsy_lo, szsy_lo;
    assign czsy_hi = r_czsy[PW-1:SW];
    assign szsy_hi = r_szsy[PW-1:SW];
    assign czsy_lo = $signed({1'b0, r_czsy[SW-1:0]});
    assign szsy_lo = $signed({1'b0, r_szsy[SW-1:0]});

    logic signed [PW-1:0] r_h1, r_h2, r_h3, r_h4;
    logic signed [PW:0]   r_l1, r_l2, r_l3, r_l4;
    logic signed [PW-1:0] r_c_czcy, r_c_szcx, r_c_szsx, r_c_szcy;
    logic signed [PW-1:0] r_c_czcx, r_c_czsx, r_c_cysx, r_c_cycx;
    t_q20                 r_c_sy;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_h1 <= czsy_hi * r_b_sx;
            r_l1 <= czsy_lo * r_b_sx;
            r_h2 <= czsy_hi * r_b_cx;
            r_l2 <= czsy_lo * r_b_cx;
            r_h3 <= szsy_hi * r_b_sx;
            r_l3 <= szsy_lo * r_b_sx;
            r_h4 <= szsy_hi * r_b_cx;
            r_l4 <= szsy_lo * r_b_cx;
            r_c_czcy <= r_czcy;
            r_c_szcx <= r_szcx;
            r_c_szsx <= r_szsx;
            r_c_szcy <= r_szcy;
            r_c_czcx <= r_czcx;
            r_c_czsx <= r_czsx;
            r_c_cysx <= r_cysx;
            r_c_cycx <= r_cycx;
            r_c_sy   <= r_b_sy;
        end
    end

    // stage d: recombine triple products in Q.60
    logic signed [AW-1:0] r_t1, r_t2, r_t3, r_t4;
    logic signed [PW-1:0] r_d_czcy, r_d_szcx, r_d_szsx, r_d_szcy;
    logic signed [PW-1:0] r_d_czcx, r_d_czsx, r_d_cysx, r_d_cycx;
    t_q20                 r_d_sy;

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_t1 <= (AW'(r_h1) <<< SW) + AW'(r_l1);
            r_t2 <= (AW'(r_h2) <<< SW) + AW'(r_l2);
            r_t3 <= (AW'(r_h3) <<< SW) + AW'(r_l3);
            r_t4 <= (AW'(r_h4) <<< SW) + AW'(r_l4);
            r_d_czcy <= r_c_czcy;
            r_d_szcx <= r_c_szcx;
            r_d_szsx <= r_c_szsx;
            r_d_szcy <= r_c_szcy;
            r_d_czcx <= r_c_czcx;
            r_d_czsx <= r_c_czsx;
            r_d_cysx <= r_c_cysx;
            r_d_cycx <= r_c_cycx;
            r_d_sy   <= r_c_sy;
        end
    end

    // stage e: final sums and rounding; pair terms carry an extra 2^20
    t_matrix r_mat;

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_mat.m00 <= f_q14(AW'(r_d_czcy) <<< 20);
            r_mat.m01 <= f_q14(r_t1 - (AW'(r_d_szcx) <<< 20));
            r_mat.m02 <= f_q14(r_t2 + (AW'(r_d_szsx) <<< 20));
            r_mat.m10 <= f_q14(AW'(r_d_szcy) <<< 20);
            r_mat.m11 <= f_q14(r_t3 + (AW'(r_d_czcx) <<< 20));
            r_mat.m12 <= f_q14(r_t4 - (AW'(r_d_czsx) <<< 20));
            r_mat.m20 <= f_q14(-(AW'(r_d_sy) <<< 40));
            r_mat.m21 <= f_q14(AW'(r_d_cysx) <<< 20);
            r_mat.m22 <= f_q14(AW'(r_d_cycx) <<< 20);
        end
    end

    assign o_mat = r_mat;

endmodule

[rtl/euler_to_rotation_matrix.sv]
// Channel   Dir  Payload                       Transfer
// i_angle   in   roll, pitch, yaw (Q3.13)      valid && ready
// o_matrix  out  m00..m22 (Q1.14)              valid && ready
// i_cfg     in   negate_angles (bit 0)         valid && ready, ready always high
//
// CORDIC_STEPS is capped at 24; one triple per cycle while the output is not stalled.
// The depth is set by the one-rotation-per-stage CORDIC plus four multiply stages.
// Reset (synchronous, active low) clears all valid bits and negate_angles.
// Stages advance independently: a stall at the output holds only full stages,
// bubbles behind it close up, and input is taken while any stage can move.
// Depends on eul_pkg, the channel interfaces, eul_cordic and eul_mat.
module euler_to_rotation_matrix #(
    parameter int CORDIC_STEPS = eul_pkg::CORDIC_STEPS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    eul_angle_if.sink    i_angle,
    eul_matrix_if.source o_matrix,
    eul_cfg_if.sink      i_cfg
);
    import eul_pkg::*;

    localparam int NSTEP = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
    localparam int NC    = NSTEP + 2;    // cordic stages
    localparam int L     = NC + 4;       // total stages

    logic          r_negate;
    logic [L-1:0]  r_vld;
    logic [L-1:0]  en;
    t_sincos       sc;
    t_matrix       mat;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_negate <= 1'b0;
        end else if (i_cfg.valid) begin
            r_negate <= i_cfg.data;
        end
    end

    // a stage may load when empty or when its content moves on
    always_comb begin
        en[L-1] = !r_vld[L-1] || o_matrix.ready;
        for (int k = L - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < L; k++) begin
                if (en[k]) begin
                    r_vld[k] <= (k == 0) ? i_angle.valid : r_vld[(k == 0) ? 0 : k-1];
                end
            end
        end
    end

    assign i_angle.ready = en[0];

    eul_cordic #(.NSTEP(NSTEP)) u_cx (
        .i_clk (i_clk), .i_en (en[NC-1:0]), .i_neg (r_negate),
        .i_ang (i_angle.roll), .o_sin (sc.sx), .o_cos (sc.cx)
    );
    eul_cordic #(.NSTEP(NSTEP)) u_cy (
        .i_clk (i_clk), .i_en (en[NC-1:0]), .i_neg (r_negate),
        .i_ang (i_angle.pitch), .o_sin (sc.sy), .o_cos (sc.cy)
    );
    eul_cordic #(.NSTEP(NSTEP)) u_cz (
        .i_clk (i_clk), .i_en (en[NC-1:0]), .i_neg (r_negate),
        .i_ang (i_angle.yaw), .o_sin (sc.sz), .o_cos (sc.cz)
    );

    eul_mat u_mat (
        .i_clk (i_clk), .i_en (en[L-1:NC]), .i_sc (sc), .o_mat (mat)
    );

    assign o_matrix.valid = r_vld[L-1];
    assign o_matrix.m00   = mat.m00;
    assign o_matrix.m01   = mat.m01;
    assign o_matrix.m02   = mat.m02;
    assign o_matrix.m10   = mat.m10;
    assign o_matrix.m11   = mat.m11;
    assign o_matrix.m12   = mat.m12;
    assign o_matrix.m20   = mat.m20;
    assign o_matrix.m21   = mat.m21;
    assign o_matrix.m22   = mat.m22;

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_matrix.valid)
        else $error("output valid right after reset");

    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_vld && !o_matrix.ready) |-> !i_angle.ready)
        else $error("input taken while pipeline full and stalled");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_matrix.valid |-> (mat.m00 <= Q14_ONE && mat.m00 >= -Q14_ONE &&
                            mat.m11 <= Q14_ONE && mat.m11 >= -Q14_ONE &&
                            mat.m22 <= Q14_ONE && mat.m22 >= -Q14_ONE))
        else $error("matrix entry beyond unity");

endmodule

[tb/sv/tb_euler_to_rotation_matrix.sv]
// Testbench for euler_to_rotation_matrix: predicts the Z-Y-X rotation matrix of each
// angle triple with a CORDIC model of its own, checks every matrix transfer in order.
// Depends on eul_pkg, the channel interfaces and the RTL top level.
module tb_euler_to_rotation_matrix;
    timeunit 1ns;
    timeprecision 1ps;
    import eul_pkg::*;

    localparam int STEPS     = 16;
    localparam int LATENCY   = 30;
    localparam int WDOG_MAX  = 2000;
    localparam int N_RANDOM  = 550;

    typedef struct packed {
        t_ang roll;
        t_ang pitch;
        t_ang yaw;
    } t_triple;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    eul_angle_if  angle_ch ();
    eul_matrix_if matrix_ch ();
    eul_cfg_if    cfg_ch ();

    euler_to_rotation_matrix #(.CORDIC_STEPS(STEPS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_angle (angle_ch.sink),
        .o_matrix(matrix_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_triple pending_angles[$];
    t_matrix expected_matrices[$];
    logic    negate_mode = 1'b0;
    int      n_errors = 0;
    int      n_matrices = 0;
    int      n_angles = 0;
    int      idle_cycles = 0;
    bit      src_quiet = 1'b0;
    bit      snk_quiet = 1'b0;
    bit      send_hold = 1'b0;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint limit(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // sine and cosine in Q1.20 of a Q3.13 angle (given at wider width)
    function automatic void cordic_sincos(input longint ang, output longint sn,
                                          output longint cs);
        longint z, x, y, dx, dy;
        bit flip;
        z = ang * 131072;
        x = Q30_GAIN;
        y = 0;
        flip = 1'b0;
        if (z > Q30_HALF_PI) begin
            z -= Q30_PI;
            flip = 1'b1;
        end else if (z < -longint'(Q30_HALF_PI)) begin
            z += Q30_PI;
            flip = 1'b1;
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_Q30[i];
            end else begin
                x += dx; y -= dy; z += ATAN_Q30[i];
            end
        end
        x = limit(floor_shift(x + 512, 10), 1048576);
        y = limit(floor_shift(y + 512, 10), 1048576);
        if (flip) begin
            x = -x; y = -y;
        end
        cs = x;
        sn = y;
    endfunction

    function automatic t_q14 round_q14(longint q60);
        return t_q14'(limit(floor_shift(q60 + (longint'(1) << 45), 46), 16384));
    endfunction

    function automatic t_matrix rotation_of(t_triple a, logic neg);
        longint ax, ay, az, sx, cx, sy, cy, sz, cz;
        longint one;
        t_matrix m;
        one = 1048576;
        ax = a.roll; ay = a.pitch; az = a.yaw;
        if (neg) begin
            ax = -ax; ay = -ay; az = -az;
        end
        cordic_sincos(ax, sx, cx);
        cordic_sincos(ay, sy, cy);
        cordic_sincos(az, sz, cz);
        m.m00 = round_q14(cz * cy * one);
        m.m01 = round_q14(-sz * cx * one + cz * sy * sx);
        m.m02 = round_q14(sz * sx * one + cz * sy * cx);
        m.m10 = round_q14(sz * cy * one);
        m.m11 = round_q14(cz * cx * one + sz * sy * sx);
        m.m12 = round_q14(-cz * sx * one + sz * sy * cx);
        m.m20 = round_q14(-sy * one * one);
        m.m21 = round_q14(cy * sx * one);
        m.m22 = round_q14(cy * cx * one);
        return m;
    endfunction

    // angle source
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            angle_ch.valid <= 1'b0;
            angle_ch.roll  <= '0;
            angle_ch.pitch <= '0;
            angle_ch.yaw   <= '0;
        end else begin
            if (angle_ch.valid && angle_ch.ready) begin
                expected_matrices.push_back(rotation_of({angle_ch.roll, angle_ch.pitch,
                                                         angle_ch.yaw}, negate_mode));
                n_angles++;
            end
            if (!(angle_ch.valid && !angle_ch.ready)) begin
                if (pending_angles.size() > 0 && !send_hold &&
                    (src_quiet || $urandom_range(99) >= 15)) begin
                    t_triple t;
                    t = pending_angles.pop_front();
                    angle_ch.valid <= 1'b1;
                    angle_ch.roll  <= t.roll;
                    angle_ch.pitch <= t.pitch;
                    angle_ch.yaw   <= t.yaw;
                end else begin
                    angle_ch.valid <= 1'b0;
                end
            end
        end
    end

    // matrix sink and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            matrix_ch.ready <= 1'b0;
        end else begin
            matrix_ch.ready <= snk_quiet || ($urandom_range(99) >= 15);
            if (matrix_ch.valid && matrix_ch.ready) begin
                n_matrices++;
                if (expected_matrices.size() == 0) begin
                    $error("matrix transfer with nothing expected");
                    n_errors++;
                end else begin
                    t_matrix e;
                    e = expected_matrices.pop_front();
                    if (matrix_ch.m00 !== e.m00) begin
                        $error("m00 exp %0d got %0d", e.m00, matrix_ch.m00); n_errors++;
                    end
                    if (matrix_ch.m01 !== e.m01) begin
                        $error("m01 exp %0d got %0d", e.m01, matrix_ch.m01); n_errors++;
                    end
                    if (matrix_ch.m02 !== e.m02) begin
                        $error("m02 exp %0d got %0d", e.m02, matrix_ch.m02); n_errors++;
                    end
                    if (matrix_ch.m10 !== e.m10) begin
                        $error("m10 exp %0d got %0d", e.m10, matrix_ch.m10); n_errors++;
                    end
                    if (matrix_ch.m11 !== e.m11) begin
                        $error("m11 exp %0d got %0d", e.m11, matrix_ch.m11); n_errors++;
                    end
                    if (matrix_ch.m12 !== e.m12) begin
                        $error("m12 exp %0d got %0d", e.m12, matrix_ch.m12); n_errors++;
                    end
                    if (matrix_ch.m20 !== e.m20) begin
                        $error("m20 exp %0d got %0d", e.m20, matrix_ch.m20); n_errors++;
                    end
                    if (matrix_ch.m21 !== e.m21) begin
                        $error("m21 exp %0d got %0d", e.m21, matrix_ch.m21); n_errors++;
                    end
                    if (matrix_ch.m22 !== e.m22) begin
                        $error("m22 exp %0d got %0d", e.m22, matrix_ch.m22); n_errors++;
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((angle_ch.valid && angle_ch.ready) || (matrix_ch.valid && matrix_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_MAX) begin
                $display("tb_euler_to_rotation_matrix: done, errors");
                $finish;
            end
        end
    end

    task automatic push_angles(input t_ang r, input t_ang p, input t_ang y);
        t_triple t;
        t.roll = r; t.pitch = p; t.yaw = y;
        pending_angles.push_back(t);
    endtask

    function automatic t_ang rand_angle();
        case ($urandom_range(9))
            0:       return t_ang'($urandom);
            1:       return t_ang'($urandom_range(3)) + 16'sh8000;
            2:       return 16'sd32767 - t_ang'($urandom_range(3));
            default: return t_ang'(int'($urandom_range(51472)) - 25736);
        endcase
    endfunction

    task automatic wait_drained();
        while (pending_angles.size() > 0 || angle_ch.valid || expected_matrices.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_negate(input logic v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        negate_mode = v;
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic load_directed();
        t_ang ext[8];
        ext = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd12868, -16'sd12868,
                16'sd32767, 16'sh8000, 16'sd12869};
        for (int i = 0; i < 8; i++) push_angles(ext[i], 16'sd0, 16'sd0);
        for (int i = 0; i < 8; i++) push_angles(16'sd0, ext[i], ext[(i + 3) % 8]);
        push_angles(16'sh8000, 16'sh8000, 16'sh8000);
        push_angles(16'sd32767, 16'sd32767, 16'sd32767);
        push_angles(-16'sd1, 16'sd1, -16'sd12869);
    endtask

    task automatic load_random(input int n);
        for (int i = 0; i < n; i++) push_angles(rand_angle(), rand_angle(), rand_angle());
    endtask

    initial begin
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = 1'b0;
        angle_ch.valid = 1'b0;
        angle_ch.roll = '0; angle_ch.pitch = '0; angle_ch.yaw = '0;
        matrix_ch.ready = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        load_directed();
        wait_drained();
        write_negate(1'b1);
        load_directed();
        wait_drained();
        write_negate(1'b0);

        load_random(150);
        // hold the sender until the pipeline has emptied
        repeat (60) @(posedge i_clk);
        send_hold = 1'b1;
        while (expected_matrices.size() > 0 || angle_ch.valid) @(posedge i_clk);
        send_hold = 1'b0;
        wait_drained();

        write_negate(1'b1);
        src_quiet = 1'b1;
        snk_quiet = 1'b1;
        load_random(150);
        wait_drained();
        src_quiet = 1'b0;
        snk_quiet = 1'b0;

        write_negate(1'b0);
        load_random(125);
        wait_drained();
        write_negate(1'b1);
        load_random(125);
        wait_drained();

        $display("covered %0d angle triples, %0d matrices, both negate settings",
                 n_angles, n_matrices);
        if (n_errors == 0) begin
            $display("tb_euler_to_rotation_matrix: done, clean");
        end else begin
            $display("tb_euler_to_rotation_matrix: done, errors");
        end
        $finish;
    end
endmodule

[sim.f]
rtl/eul_pkg.sv
rtl/eul_angle_if.sv
rtl/eul_matrix_if.sv
rtl/eul_cfg_if.sv
rtl/eul_cordic.sv
rtl/eul_mat.sv
rtl/euler_to_rotation_matrix.sv
tb/sv/tb_euler_to_rotation_matrix.sv
